FILE: design/aws_pkg.sv
// ----------------------------------------------------------------------------
// aws_pkg: shared types and constants for the affine warp sampler
// Action codes, register indexes and the fixed-point unit used by the sampler core.
// ----------------------------------------------------------------------------
package aws_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_BILIN   = 2'd1,
      ACT_NEAREST = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   localparam logic [2:0] REG_COEF_XX   = 3'd0;
   localparam logic [2:0] REG_COEF_XY   = 3'd1;
   localparam logic [2:0] REG_OFFSET_X  = 3'd2;
   localparam logic [2:0] REG_COEF_YX   = 3'd3;
   localparam logic [2:0] REG_COEF_YY   = 3'd4;
   localparam logic [2:0] REG_OFFSET_Y  = 3'd5;
   localparam logic [2:0] REG_SRC_W     = 3'd6;
   localparam logic [2:0] REG_SRC_H     = 3'd7;

   localparam int FRAC_BITS = 16;
   localparam int FX_BITS   = 48;

endpackage

FILE: design/aws_ram.sv
// ----------------------------------------------------------------------------
// aws_ram: generic single-port-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module aws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/affine_warp_sampler_core.sv
// ----------------------------------------------------------------------------
// affine_warp_sampler_core: inverse affine warp with bilinear/nearest sampling
// Source image kept in four banks (even/odd column x even/odd row) so the four
// bilinear neighbours are read together.
// ----------------------------------------------------------------------------
// One item is accepted every cycle (busy stays low). A sample puts one result
// beat on rsp_valid through the stage 1 to stage 6 registers. Writes and the
// unused action code return nothing. The result passes through the coefficient
// multipliers (two stages), corner/clamp logic, the banked source read, the
// two-stage weighted sum and the output register. The receiver cannot stall,
// so results are never held. Writes pass through the wv1_ff and wv2_ff
// registers and reach the source memory in step with the sample read stage,
// so a write is visible to samples accepted after it and never to earlier
// samples.
module affine_warp_sampler_core
   import aws_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CHANNELS   = 3,
   parameter int PIXEL_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_action,
   input  logic signed [11:0] req_coord_x,
   input  logic signed [11:0] req_coord_y,
   input  logic [1:0]   req_channel,
   input  logic [15:0]  req_pixel_in,
   input  logic [7:0]   req_mask_in,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [39:0]  csr_data,
   output logic         rsp_valid,
   output logic [7:0]   rsp_mask_out,
   output logic         rsp_pixel_valid,
   output logic [15:0]  rsp_pixel_out
);

   localparam int XB = $clog2(MAX_WIDTH);
   localparam int YB = $clog2(MAX_HEIGHT);
   localparam int CB = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int BDEPTH = ((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2);
   localparam int BAB = $clog2(BDEPTH);
   localparam int PDEPTH = CHANNELS * BDEPTH;
   localparam int PAB = $clog2(PDEPTH);
   localparam int HW = (MAX_WIDTH + 1) / 2;
   localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

   // ---------------- configuration ----------------
   logic signed [31:0] cxx_ff, cxy_ff, cyx_ff, cyy_ff;
   logic signed [39:0] ox_ff, oy_ff;
   logic [8:0]         sw_ff, sh_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cxx_ff <= 32'sd65536; cxy_ff <= '0; ox_ff <= '0;
         cyx_ff <= '0; cyy_ff <= 32'sd65536; oy_ff <= '0;
         sw_ff <= 9'd256; sh_ff <= 9'd256;
      end else if (csr_valid) begin
         case (csr_index)
            REG_COEF_XX:  cxx_ff <= csr_data[31:0];
            REG_COEF_XY:  cxy_ff <= csr_data[31:0];
            REG_OFFSET_X: ox_ff  <= csr_data;
            REG_COEF_YX:  cyx_ff <= csr_data[31:0];
            REG_COEF_YY:  cyy_ff <= csr_data[31:0];
            REG_OFFSET_Y: oy_ff  <= csr_data;
            REG_SRC_W:    sw_ff  <= csr_data[8:0];
            REG_SRC_H:    sh_ff  <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // effective size, clipped to the maximum (13 bits covers 4096)
   logic [12:0] w_eff, h_eff;
   assign w_eff = ({4'd0, sw_ff} > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : {4'd0, sw_ff};
   assign h_eff = ({4'd0, sh_ff} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, sh_ff};

   // ---------------- stage 0: accept, write path ----------------
   logic acc;
   logic is_samp;
   assign acc = start & ~busy;
   assign is_samp = acc & (req_action == ACT_BILIN || req_action == ACT_NEAREST);

   logic wr_ok;
   assign wr_ok = acc && req_action == ACT_WRITE && req_coord_x >= 0 && req_coord_y >= 0
                  && 32'(req_coord_x) < MAX_WIDTH && 32'(req_coord_y) < MAX_HEIGHT
                  && 32'(req_channel) < CHANNELS;

   logic [XB-1:0] wx;
   logic [YB-1:0] wy;
   logic [CB-1:0] wch;
   assign wx  = req_coord_x[XB-1:0];
   assign wy  = req_coord_y[YB-1:0];
   assign wch = req_channel[CB-1:0];

   // stage 1: products
   logic              v1_ff, bl1_ff, chok1_ff;
   logic [CB-1:0]     ch1_ff;
   logic signed [43:0] pxx_ff, pxy_ff, pyx_ff, pyy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= is_samp;
      end
      bl1_ff   <= req_action == ACT_BILIN;
      chok1_ff <= 32'(req_channel) < CHANNELS;
      ch1_ff   <= req_channel[CB-1:0];
      pxx_ff   <= cxx_ff * req_coord_x;
      pxy_ff   <= cxy_ff * req_coord_y;
      pyx_ff   <= cyx_ff * req_coord_x;
      pyy_ff   <= cyy_ff * req_coord_y;
   end

   // stage 2: sums
   logic              v2_ff, bl2_ff, chok2_ff;
   logic [CB-1:0]     ch2_ff;
   logic signed [FX_BITS-1:0] fx_ff, fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      bl2_ff   <= bl1_ff;
      chok2_ff <= chok1_ff;
      ch2_ff   <= ch1_ff;
      fx_ff    <= FX_BITS'(pxx_ff) + FX_BITS'(pxy_ff) + FX_BITS'(ox_ff);
      fy_ff    <= FX_BITS'(pyx_ff) + FX_BITS'(pyy_ff) + FX_BITS'(oy_ff);
   end

   // stage 2 comb: corners, clamps, addresses
   localparam int IB = FX_BITS - FRAC_BITS;
   logic signed [IB-1:0] xs, ys, xs1, ys1, xa, ya, xa1, ya1, xn, yn;
   logic signed [FX_BITS-1:0] fxr, fyr;
   logic [15:0] u, v;
   logic in_b, in_n;

   always_comb begin
      xs  = fx_ff[FX_BITS-1:FRAC_BITS];
      ys  = fy_ff[FX_BITS-1:FRAC_BITS];
      u   = fx_ff[15:0];
      v   = fy_ff[15:0];
      xs1 = xs + IB'(1);
      ys1 = ys + IB'(1);
      xa  = (xs < 0) ? xs + IB'(1) : xs;
      ya  = (ys < 0) ? ys + IB'(1) : ys;
      xa1 = (xs1 >= $signed({1'b0, w_eff})) ? xs1 - IB'(1) : xs1;
      ya1 = (ys1 >= $signed({1'b0, h_eff})) ? ys1 - IB'(1) : ys1;
      in_b = xa >= 0 && ya >= 0 && xa < $signed({1'b0, w_eff})
             && ya < $signed({1'b0, h_eff});
      if (xa1 == xa) u = '0;
      if (ya1 == ya) v = '0;
      fxr = fx_ff + FX_BITS'(32768);
      fyr = fy_ff + FX_BITS'(32768);
      // truncation toward zero: negative values above -1 land on 0, values at or below -1 give -1
      xn  = (fxr < 0) ? ((fxr > -FX_BITS'(65536)) ? '0 : IB'(-1)) : fxr[FX_BITS-1:FRAC_BITS];
      yn  = (fyr < 0) ? ((fyr > -FX_BITS'(65536)) ? '0 : IB'(-1)) : fyr[FX_BITS-1:FRAC_BITS];
      in_n = xn >= 0 && yn >= 0 && xn < $signed({1'b0, w_eff})
             && yn < $signed({1'b0, h_eff});
   end

   // bank addressing: corner pair (x0,x1),(y0,y1); bank by column/row parity
   logic [XB-1:0] cx0, cx1;
   logic [YB-1:0] cy0, cy1;
   always_comb begin
      if (bl2_ff) begin
         cx0 = xa[XB-1:0];  cx1 = xa1[XB-1:0];
         cy0 = ya[YB-1:0];  cy1 = ya1[YB-1:0];
      end else begin
         cx0 = xn[XB-1:0];  cx1 = xn[XB-1:0];
         cy0 = yn[YB-1:0];  cy1 = yn[YB-1:0];
      end
   end

   function automatic logic [PAB-1:0] paddr(input logic [CB-1:0] c,
                                             input logic [XB-1:0] x,
                                             input logic [YB-1:0] y);
      logic [PAB+XB+YB-1:0] t;
      begin
         t = (PAB+XB+YB)'(c) * (PAB+XB+YB)'(BDEPTH)
             + (PAB+XB+YB)'(y >> 1) * (PAB+XB+YB)'(HW) + (PAB+XB+YB)'(x >> 1);
         return t[PAB-1:0];
      end
   endfunction

   function automatic logic [BAB-1:0] maddr(input logic [XB-1:0] x,
                                            input logic [YB-1:0] y);
      logic [BAB+XB+YB-1:0] t;
      begin
         t = (BAB+XB+YB)'(y >> 1) * (BAB+XB+YB)'(HW) + (BAB+XB+YB)'(x >> 1);
         return t[BAB-1:0];
      end
   endfunction

   // four banks indexed [row parity][col parity]
   logic [PIXEL_BITS-1:0] prd [4];
   logic [PAB-1:0]        pra [4];
   logic [PAB-1:0]        pwa;
   logic [BAB-1:0]        mwa, mra;
   logic [7:0]            mrd;
   logic [1:0]            wbank;

   assign wbank = {wy[0], wx[0]};
   assign pwa   = paddr(wch, wx, wy);
   assign mwa   = maddr(wx, wy);
   assign mra   = maddr(cx0, cy0);

   // write beats are delayed through wv1_ff and wv2_ff, in step with the read stage
   logic                  wv1_ff, wv2_ff;
   logic [1:0]            wb1_ff, wb2_ff;
   logic [PAB-1:0]        pwa1_ff, pwa2_ff;
   logic [BAB-1:0]        mwa1_ff, mwa2_ff;
   logic [PIXEL_BITS-1:0] wd1_ff, wd2_ff;
   logic [7:0]            wm1_ff, wm2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         wv1_ff <= 1'b0;
         wv2_ff <= 1'b0;
      end else begin
         wv1_ff <= wr_ok;
         wv2_ff <= wv1_ff;
      end
      wb1_ff  <= wbank;
      wb2_ff  <= wb1_ff;
      pwa1_ff <= pwa;
      pwa2_ff <= pwa1_ff;
      mwa1_ff <= mwa;
      mwa2_ff <= mwa1_ff;
      wd1_ff  <= req_pixel_in[PIXEL_BITS-1:0];
      wd2_ff  <= wd1_ff;
      wm1_ff  <= req_mask_in;
      wm2_ff  <= wm1_ff;
   end

   // each bank: corner (col, row) whose parities match
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         pra[b] = paddr(ch2_ff,
                        (cx0[0] == b[0]) ? cx0 : cx1,
                        (cy0[0] == b[1]) ? cy0 : cy1);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      aws_ram #(.WIDTH(PIXEL_BITS), .DEPTH(PDEPTH)) u_pix (
         .clock  (clock),
         .wr_en  (wv2_ff && wb2_ff == 2'(g)),
         .wr_addr(pwa2_ff),
         .wr_data(wd2_ff),
         .rd_addr(pra[g]),
         .rd_data(prd[g])
      );
   end

   aws_ram #(.WIDTH(8), .DEPTH(BDEPTH * 4)) u_mask (
      .clock  (clock),
      .wr_en  (wv2_ff),
      .wr_addr({wb2_ff, mwa2_ff}),
      .wr_data(wm2_ff),
      .rd_addr({cy0[0], cx0[0], mra}),
      .rd_data(mrd)
   );

   // stage 3: memory read in flight
   logic       v3_ff, bl3_ff, ok3_ff;
   logic [15:0] u3_ff, v3w_ff;
   logic       px3_ff, py3_ff;   // parity of near corner
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      bl3_ff <= bl2_ff;
      ok3_ff <= chok2_ff && (bl2_ff ? in_b : in_n);
      u3_ff  <= u;
      v3w_ff <= v;
      px3_ff <= cx0[0];
      py3_ff <= cy0[0];
   end

   // stage 3 comb: route banks to corners, first products
   logic [PIXEL_BITS-1:0] p00, p01, p10, p11;
   always_comb begin
      p00 = prd[{py3_ff, px3_ff}];
      p01 = prd[{py3_ff, ~px3_ff}];
      p10 = prd[{~py3_ff, px3_ff}];
      p11 = prd[{~py3_ff, ~px3_ff}];
   end

   logic [16:0] uc, vc;
   assign uc = 17'd65536 - {1'b0, u3_ff};

   // stage 4: row blends
   logic        v4_ff, bl4_ff, ok4_ff;
   logic [7:0]  m4_ff;
   logic [PIXEL_BITS-1:0] pn4_ff;
   logic [PIXEL_BITS+16:0] top4_ff, bot4_ff;
   logic [15:0] vw4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      bl4_ff  <= bl3_ff;
      ok4_ff  <= ok3_ff;
      m4_ff   <= mrd;
      pn4_ff  <= p00;
      vw4_ff  <= v3w_ff;
      top4_ff <= (PIXEL_BITS+17)'(p00) * uc + (PIXEL_BITS+17)'(p01) * u3_ff;
      bot4_ff <= (PIXEL_BITS+17)'(p10) * uc + (PIXEL_BITS+17)'(p11) * u3_ff;
   end

   assign vc = 17'd65536 - {1'b0, vw4_ff};

   // stage 5: vertical blend
   logic        v5_ff, bl5_ff, ok5_ff;
   logic [7:0]  m5_ff;
   logic [PIXEL_BITS-1:0] pn5_ff;
   logic [PIXEL_BITS+33:0] acc5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      bl5_ff  <= bl4_ff;
      ok5_ff  <= ok4_ff;
      m5_ff   <= m4_ff;
      pn5_ff  <= pn4_ff;
      acc5_ff <= (PIXEL_BITS+34)'(top4_ff) * vc + (PIXEL_BITS+34)'(bot4_ff) * vw4_ff;
   end

   // stage 5 comb: round, saturate, select
   logic [PIXEL_BITS+33:0] rnd;
   logic [PIXEL_BITS+1:0]  rq;
   logic [PIXEL_BITS-1:0]  bpix;
   logic [7:0]             o_mask;
   logic                   o_pv;
   logic [15:0]            o_pix;
   always_comb begin
      rnd  = acc5_ff + (PIXEL_BITS+34)'(64'h8000_0000);
      rq   = rnd[PIXEL_BITS+33:32];
      bpix = (rq > (PIXEL_BITS+2)'(PIX_MAX)) ? PIX_MAX : rq[PIXEL_BITS-1:0];
      o_mask = '0;
      o_pv   = 1'b0;
      o_pix  = '0;
      if (ok5_ff) begin
         if (bl5_ff) begin
            o_mask = m5_ff;
            if (m5_ff != 8'd0) begin
               o_pv  = 1'b1;
               o_pix = 16'(bpix);
            end
         end else begin
            o_pv  = 1'b1;
            o_pix = 16'(pn5_ff);
         end
      end
   end

   // stage 6: output register
   logic        rv_ff, rpv_ff;
   logic [7:0]  rm_ff;
   logic [15:0] rp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= v5_ff;
      end
      rm_ff  <= o_mask;
      rpv_ff <= o_pv;
      rp_ff  <= o_pix;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_mask_out    = rm_ff;
   assign rsp_pixel_valid = rpv_ff;
   assign rsp_pixel_out   = rp_ff;

`ifndef SYNTH
   a_no_busy: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy asserted");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> ##4 rsp_valid)
      else $error("result beat missing");
   a_zero_pix: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pixel_valid) |-> rsp_pixel_out == 16'd0)
      else $error("pixel nonzero when invalid");
   a_mask_pv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mask_out != 8'd0 && !rsp_pixel_valid) |-> 1'b0)
      else $error("mask set without pixel");
`endif

endmodule
